[src/jpeg_marker_segment_filter_macros.svh]
// ----------------------------------------------------------------------------
// jpeg_marker_segment_filter_macros.svh
// Assertion macros shared by the marker segment filter RTL.
// ----------------------------------------------------------------------------
`ifndef JPEG_MARKER_SEGMENT_FILTER_MACROS_SVH
`define JPEG_MARKER_SEGMENT_FILTER_MACROS_SVH

// expr holds on every clock edge out of reset
`define JMSF_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// post holds in the cycle after pre
`define JMSF_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[src/jmsf_pkg.sv]
// ----------------------------------------------------------------------------
// jmsf_pkg
// Types and constants shared by the marker segment filter modules.
// ----------------------------------------------------------------------------
package jmsf_pkg;

	localparam int MAX_FILE_BYTES = 1048576;
	localparam int LEN_W          = 21;
	localparam int REMAIN_W       = 16;
	localparam int GROUP_BYTES    = 4;
	localparam int QUEUE_DEPTH    = 4;               // power of two
	localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] MK_FILL  = 8'hFF;
	localparam logic [7:0] MK_COM   = 8'hFE;
	localparam logic [7:0] MK_APP2  = 8'hE2;
	localparam logic [7:0] MK_APP15 = 8'hEF;
	localparam logic [7:0] MK_SOS   = 8'hDA;
	localparam logic [7:0] MK_SOI   = 8'hD8;
	localparam logic [7:0] MK_EOI   = 8'hD9;
	localparam logic [7:0] MK_RST0  = 8'hD0;
	localparam logic [7:0] MK_RST7  = 8'hD7;
	localparam logic [7:0] MK_TEM   = 8'h01;

	// bytes released by one input transfer; cnt is 1..GROUP_BYTES
	typedef struct packed {
		logic [GROUP_BYTES-1:0][7:0] bytes;
		logic [2:0]                  cnt;
		logic                        empty;
		logic                        last;
		logic [LEN_W-1:0]            length;
	} group_t;

endpackage

[src/jmsf_in_if.sv]
// ----------------------------------------------------------------------------
// jmsf_in_if
// Input byte channel: valid/ready with one file byte per transfer.
// ----------------------------------------------------------------------------
interface jmsf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

[src/jmsf_out_if.sv]
// ----------------------------------------------------------------------------
// jmsf_out_if
// Result channel: valid/ready with one filtered byte or end marker.
// ----------------------------------------------------------------------------
interface jmsf_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        out_valid;
	logic        out_last;
	logic [20:0] out_length;

	modport source (output valid, output out_byte, output out_valid, output out_last,
		output out_length, input ready);
	modport sink (input valid, input out_byte, input out_valid, input out_last,
		input out_length, output ready);
endinterface

[src/jmsf_front.sv]
// ----------------------------------------------------------------------------
// jmsf_front
// Marker walker: takes one byte per transfer, classifies it and pushes the
// bytes it releases as one group into the queue.
// ----------------------------------------------------------------------------
module jmsf_front
	import jmsf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [LEN_W-1:0]  cfg_wdata,
	jmsf_in_if.sink           jpeg,
	output logic              push,
	output group_t            push_data,
	input  logic              full
);

	typedef enum logic [2:0] {
		M_START0, M_START1, M_MARK, M_MARKID, M_LENHI, M_LENLO, M_BODY, M_PASS
	} mode_t;

	localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_FILE_BYTES);

	mode_t               mode_q, mode_n;
	logic [LEN_W-1:0]    total_len_q;
	logic [LEN_W-1:0]    pos_q;
	logic [LEN_W-1:0]    seg_start_q, seg_start_n;
	logic [7:0]          marker_q, marker_n;
	logic [7:0]          len_hi_q, len_hi_n;
	logic [REMAIN_W-1:0] remain_q, remain_n;
	logic [LEN_W-1:0]    emitted_q;

	logic [GROUP_BYTES-1:0][7:0] obytes;
	logic [2:0]                  cnt;
	logic [15:0]                 seg_len;
	logic [REMAIN_W-1:0]         remain_dec;
	logic                        near_end, too_long, xfer;
	logic [7:0]                  b;

	function automatic logic is_dropped(input logic [7:0] m);
		return m == MK_COM || (m >= MK_APP2 && m <= MK_APP15);
	endfunction

	function automatic logic is_bare(input logic [7:0] m);
		return m == MK_SOI || m == MK_EOI || (m >= MK_RST0 && m <= MK_RST7) || m == MK_TEM;
	endfunction

	assign b          = jpeg.in_byte;
	assign xfer       = jpeg.valid && jpeg.ready;
	assign jpeg.ready = !full;
	assign seg_len    = {len_hi_q, b};
	assign remain_dec = remain_q - REMAIN_W'(1);
	assign near_end   = ({1'b0, pos_q} + (LEN_W+1)'(3)) >= {1'b0, total_len_q};
	assign too_long   = ({1'b0, seg_start_q} + (LEN_W+1)'(2) + (LEN_W+1)'(seg_len))
		> {1'b0, total_len_q};

	always_comb begin
		mode_n      = mode_q;
		seg_start_n = seg_start_q;
		marker_n    = marker_q;
		len_hi_n    = len_hi_q;
		remain_n    = remain_q;
		obytes      = '0;
		cnt         = 3'd0;
		case (mode_q)
			M_START0: begin
				if (total_len_q < LEN_W'(4) || b != MK_FILL) begin
					mode_n = M_PASS;
					obytes[cnt[1:0]] = b; cnt = cnt + 3'd1;
				end else begin
					mode_n = M_START1;
				end
			end
			M_START1: begin
				obytes[cnt[1:0]] = MK_FILL; cnt = cnt + 3'd1;
				obytes[cnt[1:0]] = b; cnt = cnt + 3'd1;
				mode_n = (b == MK_SOI) ? M_MARK : M_PASS;
			end
			M_MARK: begin
				if (near_end || b != MK_FILL) begin
					mode_n = M_PASS;
					obytes[cnt[1:0]] = b; cnt = cnt + 3'd1;
				end else begin
					seg_start_n = pos_q;
					mode_n      = M_MARKID;
				end
			end
			M_MARKID: begin
				if (b == MK_FILL) begin
					obytes[cnt[1:0]] = MK_FILL; cnt = cnt + 3'd1;
					if (near_end) begin
						mode_n = M_PASS;
						obytes[cnt[1:0]] = MK_FILL; cnt = cnt + 3'd1;
					end else begin
						seg_start_n = pos_q;
					end
				end else if (is_bare(b)) begin
					obytes[cnt[1:0]] = MK_FILL; cnt = cnt + 3'd1;
					obytes[cnt[1:0]] = b; cnt = cnt + 3'd1;
					mode_n = M_MARK;
				end else begin
					marker_n = b;
					mode_n   = M_LENHI;
				end
			end
			M_LENHI: begin
				len_hi_n = b;
				mode_n   = M_LENLO;
			end
			M_LENLO: begin
				if (seg_len < 16'd2 || too_long || marker_q == MK_SOS) begin
					obytes = {b, len_hi_q, marker_q, MK_FILL};
					cnt    = 3'd4;
					mode_n = M_PASS;
				end else begin
					if (!is_dropped(marker_q)) begin
						obytes = {b, len_hi_q, marker_q, MK_FILL};
						cnt    = 3'd4;
					end
					remain_n = seg_len - 16'd2;
					mode_n   = (seg_len != 16'd2) ? M_BODY : M_MARK;
				end
			end
			M_BODY: begin
				if (!is_dropped(marker_q)) begin
					obytes[cnt[1:0]] = b; cnt = cnt + 3'd1;
				end
				remain_n = remain_dec;
				if (remain_dec == '0) mode_n = M_MARK;
			end
			default: begin
				obytes[cnt[1:0]] = b; cnt = cnt + 3'd1;
			end
		endcase

		// flush held bytes on the final byte
		if (jpeg.in_last) begin
			case (mode_n)
				M_START1, M_MARKID: begin
					obytes[cnt[1:0]] = MK_FILL; cnt = cnt + 3'd1;
				end
				M_LENHI: begin
					obytes[cnt[1:0]] = MK_FILL; cnt = cnt + 3'd1;
					obytes[cnt[1:0]] = marker_n; cnt = cnt + 3'd1;
				end
				M_LENLO: begin
					obytes[cnt[1:0]] = MK_FILL; cnt = cnt + 3'd1;
					obytes[cnt[1:0]] = marker_n; cnt = cnt + 3'd1;
					obytes[cnt[1:0]] = len_hi_n; cnt = cnt + 3'd1;
				end
				default: ;
			endcase
		end
	end

	assign push             = xfer && (cnt != 3'd0 || jpeg.in_last);
	assign push_data.bytes  = obytes;
	assign push_data.cnt    = (cnt == 3'd0) ? 3'd1 : cnt;
	assign push_data.empty  = (cnt == 3'd0);
	assign push_data.last   = jpeg.in_last;
	assign push_data.length = emitted_q + LEN_W'(cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_len_q <= '0;
		end else if (cfg_we) begin
			total_len_q <= (cfg_wdata > MaxLen) ? MaxLen : cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_START0;
			pos_q       <= '0;
			seg_start_q <= '0;
			marker_q    <= '0;
			len_hi_q    <= '0;
			remain_q    <= '0;
			emitted_q   <= '0;
		end else if (xfer) begin
			if (jpeg.in_last) begin
				mode_q      <= M_START0;
				pos_q       <= '0;
				seg_start_q <= '0;
				marker_q    <= '0;
				len_hi_q    <= '0;
				remain_q    <= '0;
				emitted_q   <= '0;
			end else begin
				mode_q      <= mode_n;
				pos_q       <= pos_q + LEN_W'(1);
				seg_start_q <= seg_start_n;
				marker_q    <= marker_n;
				len_hi_q    <= len_hi_n;
				remain_q    <= remain_n;
				emitted_q   <= emitted_q + LEN_W'(cnt);
			end
		end
	end

endmodule

[src/jmsf_queue.sv]
// ----------------------------------------------------------------------------
// jmsf_queue
// Short group queue between the marker walker and the byte serializer.
// ----------------------------------------------------------------------------
module jmsf_queue
	import jmsf_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  group_t push_data,
	output logic   full,
	input  logic   pop,
	output group_t pop_data,
	output logic   nonempty
);

	group_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;

	assign full     = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + (QUEUE_AW+1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/jmsf_back.sv]
// ----------------------------------------------------------------------------
// jmsf_back
// Byte serializer: unpacks queued groups into one result per transfer.
// ----------------------------------------------------------------------------
`include "jpeg_marker_segment_filter_macros.svh"

module jmsf_back
	import jmsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       nonempty,
	input  group_t     pop_data,
	output logic       pop,
	jmsf_out_if.source filtered
);

	group_t      cur_q;
	logic        cur_valid_q;
	logic [1:0]  idx_q;
	logic        out_xfer, at_end, final_result;

	assign out_xfer     = cur_valid_q && filtered.ready;
	assign at_end       = (idx_q == 2'(cur_q.cnt - 3'd1));
	assign final_result = cur_q.last && at_end;
	assign pop          = nonempty && (!cur_valid_q || (out_xfer && at_end));

	assign filtered.valid      = cur_valid_q;
	assign filtered.out_byte   = cur_q.bytes[idx_q];
	assign filtered.out_valid  = !cur_q.empty;
	assign filtered.out_last   = final_result;
	assign filtered.out_length = final_result ? cur_q.length : '0;

	always_ff @(posedge clk) begin
		if (pop) cur_q <= pop_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (out_xfer) begin
			if (at_end) cur_valid_q <= 1'b0;
			else idx_q <= idx_q + 2'd1;
		end
	end

	`JMSF_ASSERT(a_idx_in_group, !cur_valid_q || ({1'b0, idx_q} < cur_q.cnt), "index past group")
	`JMSF_ASSERT(a_empty_is_last, !cur_valid_q || !cur_q.empty || cur_q.last, "empty not last")
	`JMSF_ASSERT_NEXT(a_stall_holds, cur_valid_q && !filtered.ready, $stable(idx_q) && cur_valid_q, "stall lost")

endmodule

[src/jpeg_marker_segment_filter.sv]
// ----------------------------------------------------------------------------
// jpeg_marker_segment_filter
// Strips COM and APP2..APP15 segments from a JPEG byte stream.
// ----------------------------------------------------------------------------
// Write total_length, then stream the file one byte per transfer on jpeg with
// in_last on the final byte. One byte is accepted every cycle while the queue
// has room; the walker releases 0 to 4 bytes per byte as a group into a
// four-group queue, and the serializer drains one result per cycle while
// filtered.ready is high. Input stalls only when the queue is full, i.e. when
// the output side falls behind. The first result of a byte passes through the
// queue and the serializer's group register before it is offered. A file that
// releases nothing on its last byte ends with one empty result (out_valid 0,
// out_last 1); out_length on the last result is the number of bytes emitted
// for the file.
module jpeg_marker_segment_filter
	import jmsf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	jmsf_in_if.sink          jpeg,
	jmsf_out_if.source       filtered
);

	logic   push, full, pop, nonempty;
	group_t push_data, pop_data;

	jmsf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.jpeg      (jpeg),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	jmsf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.nonempty  (nonempty)
	);

	jmsf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.nonempty (nonempty),
		.pop_data (pop_data),
		.pop      (pop),
		.filtered (filtered)
	);

endmodule

[tb/sv/jpeg_marker_segment_filter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_marker_segment_filter_tb
// Streams JPEG-like files through the marker segment filter.
// Most files get their own total_length setting. A mirror of the segment walker
// predicts every filtered byte, and the monitor checks each result against it.
// Sender and receiver idle at random. The run mixes directed files, random
// well-formed files, broken files and noise.
// ----------------------------------------------------------------------------
module jpeg_marker_segment_filter_tb;
	import jmsf_pkg::*;

	localparam logic [7:0] MK_SOF0 = 8'hC0;
	localparam logic [7:0] MK_DHT  = 8'hC4;
	localparam logic [7:0] MK_DQT  = 8'hDB;
	localparam logic [7:0] MK_DRI  = 8'hDD;
	localparam logic [7:0] MK_APP0 = 8'hE0;
	localparam logic [7:0] MK_APP1 = 8'hE1;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_BYTES = 130;

	typedef enum logic [2:0] {
		WALK_SOI_FF, WALK_SOI_ID, WALK_MARK, WALK_MARK_ID,
		WALK_LEN_HI, WALK_LEN_LO, WALK_BODY, WALK_PASS
	} walk_state_t;

	typedef struct {
		logic [7:0] data;
		logic       fin;
		bit         drain_first;
	} file_byte_t;

	typedef struct {
		logic [7:0]       data;
		logic             present;
		logic             fin;
		logic [LEN_W-1:0] length;
	} filtered_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [LEN_W-1:0] cfg_wdata = '0;

	jmsf_in_if  jpeg_ch ();
	jmsf_out_if filt_ch ();

	jpeg_marker_segment_filter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.jpeg     (jpeg_ch),
		.filtered (filt_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// walker mirror
	logic [LEN_W-1:0] file_len_cfg;
	walk_state_t      walk_state;
	logic [LEN_W-1:0] walk_pos;
	logic [LEN_W-1:0] seg_base;
	logic [7:0]       cur_marker;
	logic [7:0]       len_hi_byte;
	logic [15:0]      body_left;
	logic [LEN_W-1:0] sent_count;
	logic [7:0]       step_out[$];

	file_byte_t file_stream[$];
	filtered_t  filtered_due[$];
	logic [7:0] file_buf[$];

	file_byte_t next_item;
	filtered_t  want;
	int send_wait;
	int recv_wait;
	int mismatches = 0;
	int idle_cycles = 0;
	bit calm_phase = 1'b0;

	function automatic void reset_walk();
		walk_state  = WALK_SOI_FF;
		walk_pos    = '0;
		seg_base    = '0;
		cur_marker  = '0;
		len_hi_byte = '0;
		body_left   = '0;
		sent_count  = '0;
	endfunction

	function automatic void release_byte(input logic [7:0] b);
		if (step_out.size() < GROUP_BYTES) begin
			step_out.push_back(b);
			sent_count = sent_count + 1'b1;
		end
	endfunction

	function automatic bit is_dropped(input logic [7:0] m);
		return m == MK_COM || (m >= MK_APP2 && m <= MK_APP15);
	endfunction

	function automatic bit is_bare(input logic [7:0] m);
		return m == MK_SOI || m == MK_EOI || (m >= MK_RST0 && m <= MK_RST7) || m == MK_TEM;
	endfunction

	// a marker is due at position p
	function automatic void open_marker(input logic [7:0] b, input logic [LEN_W-1:0] p);
		if (32'(p) + 32'd3 >= 32'(file_len_cfg) || b != MK_FILL) begin
			walk_state = WALK_PASS;
			release_byte(b);
		end else begin
			seg_base   = p;
			walk_state = WALK_MARK_ID;
		end
	endfunction

	task automatic filter_byte(input logic [7:0] b, input logic fin);
		logic [LEN_W-1:0] p;
		logic [15:0]      seg;
		filtered_t        r;
		int               n;
		p = walk_pos;
		step_out.delete();
		case (walk_state)
			WALK_SOI_FF: begin
				if (32'(file_len_cfg) < 32'd4 || b != MK_FILL) begin
					walk_state = WALK_PASS;
					release_byte(b);
				end else
					walk_state = WALK_SOI_ID;
			end
			WALK_SOI_ID: begin
				release_byte(MK_FILL);
				release_byte(b);
				walk_state = (b == MK_SOI) ? WALK_MARK : WALK_PASS;
			end
			WALK_MARK: open_marker(b, p);
			WALK_MARK_ID: begin
				if (b == MK_FILL) begin
					release_byte(MK_FILL);
					open_marker(b, p);
				end else if (is_bare(b)) begin
					release_byte(MK_FILL);
					release_byte(b);
					walk_state = WALK_MARK;
				end else begin
					cur_marker = b;
					walk_state = WALK_LEN_HI;
				end
			end
			WALK_LEN_HI: begin
				len_hi_byte = b;
				walk_state  = WALK_LEN_LO;
			end
			WALK_LEN_LO: begin
				seg = {len_hi_byte, b};
				if (seg < 16'd2 || 32'(seg_base) + 32'd2 + 32'(seg) > 32'(file_len_cfg) ||
						cur_marker == MK_SOS) begin
					release_byte(MK_FILL);
					release_byte(cur_marker);
					release_byte(len_hi_byte);
					release_byte(b);
					walk_state = WALK_PASS;
				end else begin
					if (!is_dropped(cur_marker)) begin
						release_byte(MK_FILL);
						release_byte(cur_marker);
						release_byte(len_hi_byte);
						release_byte(b);
					end
					body_left  = seg - 16'd2;
					walk_state = (body_left != 0) ? WALK_BODY : WALK_MARK;
				end
			end
			WALK_BODY: begin
				if (!is_dropped(cur_marker))
					release_byte(b);
				body_left = body_left - 1'b1;
				if (body_left == 0)
					walk_state = WALK_MARK;
			end
			default: release_byte(b);
		endcase
		walk_pos = walk_pos + 1'b1;

		if (fin) begin
			case (walk_state)
				WALK_SOI_ID, WALK_MARK_ID: release_byte(MK_FILL);
				WALK_LEN_HI: begin
					release_byte(MK_FILL);
					release_byte(cur_marker);
				end
				WALK_LEN_LO: begin
					release_byte(MK_FILL);
					release_byte(cur_marker);
					release_byte(len_hi_byte);
				end
				default: ;
			endcase
		end

		n = step_out.size();
		if (fin && n == 0) begin
			r = '{8'h00, 1'b0, 1'b1, sent_count};
			filtered_due.push_back(r);
		end
		for (int i = 0; i < n; i++) begin
			r.data    = step_out[i];
			r.present = 1'b1;
			r.fin     = fin && (i == n - 1);
			r.length  = r.fin ? sent_count : '0;
			filtered_due.push_back(r);
		end
		if (fin)
			reset_walk();
	endtask

	function automatic int draw_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jpeg_ch.valid   <= 1'b0;
			jpeg_ch.in_byte <= '0;
			jpeg_ch.in_last <= 1'b0;
			send_wait       <= 0;
		end else begin
			if (jpeg_ch.valid && jpeg_ch.ready)
				filter_byte(jpeg_ch.in_byte, jpeg_ch.in_last);
			if (!jpeg_ch.valid || jpeg_ch.ready) begin
				if (send_wait != 0) begin
					send_wait     <= send_wait - 1;
					jpeg_ch.valid <= 1'b0;
				end else if (file_stream.size() != 0 &&
						!(file_stream[0].drain_first && filtered_due.size() != 0)) begin
					next_item = file_stream.pop_front();
					jpeg_ch.valid   <= 1'b1;
					jpeg_ch.in_byte <= next_item.data;
					jpeg_ch.in_last <= next_item.fin;
					send_wait       <= draw_gap(calm_phase);
				end else
					jpeg_ch.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_ch.ready <= 1'b0;
			recv_wait     <= 0;
		end else begin
			if (filt_ch.valid && filt_ch.ready) begin
				if (filtered_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: byte=%02h valid=%0b last=%0b len=%0d",
							filt_ch.out_byte, filt_ch.out_valid, filt_ch.out_last,
							filt_ch.out_length);
				end else begin
					want = filtered_due.pop_front();
					if (filt_ch.out_byte !== want.data || filt_ch.out_valid !== want.present ||
							filt_ch.out_last !== want.fin || filt_ch.out_length !== want.length) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp byte=%02h valid=%0b last=%0b len=%0d, %s",
								want.data, want.present, want.fin, want.length,
								$sformatf("got byte=%02h valid=%0b last=%0b len=%0d",
									filt_ch.out_byte, filt_ch.out_valid, filt_ch.out_last,
									filt_ch.out_length));
					end
				end
			end
			if (recv_wait != 0) begin
				recv_wait     <= recv_wait - 1;
				filt_ch.ready <= 1'b0;
			end else begin
				filt_ch.ready <= 1'b1;
				recv_wait     <= draw_gap(calm_phase);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((jpeg_ch.valid && jpeg_ch.ready) || (filt_ch.valid && filt_ch.ready))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("== FAIL ==");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic wait_idle(input int settle);
		@(negedge clk);
		while (file_stream.size() != 0 || jpeg_ch.valid || filtered_due.size() != 0)
			@(negedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_file_length(input logic [LEN_W-1:0] v);
		wait_idle(8);
		@(posedge clk);
		cfg_we       <= 1'b1;
		cfg_wdata    <= v;
		file_len_cfg = (32'(v) > MAX_FILE_BYTES) ? LEN_W'(MAX_FILE_BYTES) : v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_file(input int hold_at);
		file_byte_t it;
		@(negedge clk);
		foreach (file_buf[i]) begin
			it.data        = file_buf[i];
			it.fin         = (i == file_buf.size() - 1);
			it.drain_first = (i == hold_at);
			file_stream.push_back(it);
		end
	endtask

	task automatic add_segment(input logic [7:0] m, input int plen, input bit bad_len);
		logic [15:0] seg_len;
		seg_len = 16'(plen + 2);
		if (bad_len) begin
			case ($urandom_range(0, 3))
				0: seg_len = 16'd0;
				1: seg_len = 16'd1;
				2: seg_len = 16'hFFFF;
				default: seg_len = 16'($urandom);
			endcase
		end
		file_buf.push_back(MK_FILL);
		file_buf.push_back(m);
		file_buf.push_back(seg_len[15:8]);
		file_buf.push_back(seg_len[7:0]);
		repeat (plen) file_buf.push_back(8'($urandom));
	endtask

	task automatic build_wellformed(input bit broken);
		int nseg;
		int bad_at;
		int r;
		logic [7:0] m;
		file_buf.delete();
		file_buf.push_back(MK_FILL);
		file_buf.push_back(MK_SOI);
		nseg   = $urandom_range(1, 5);
		bad_at = broken ? $urandom_range(0, nseg) : -1;
		for (int k = 0; k < nseg; k++) begin
			if ($urandom_range(0, 4) == 0)
				file_buf.push_back(MK_FILL);
			r = $urandom_range(0, 2);
			if (r == 0) begin
				m = ($urandom_range(0, 3) == 0) ? MK_COM : 8'($urandom_range(MK_APP2, MK_APP15));
				add_segment(m, $urandom_range(0, 6), k == bad_at);
			end else if (r == 1) begin
				case ($urandom_range(0, 5))
					0: m = MK_SOF0;
					1: m = MK_DHT;
					2: m = MK_DQT;
					3: m = MK_DRI;
					4: m = MK_APP0;
					default: m = MK_APP1;
				endcase
				add_segment(m, $urandom_range(0, 6), k == bad_at);
			end else begin
				case ($urandom_range(0, 3))
					0: m = MK_TEM;
					1: m = MK_SOI;
					2: m = MK_EOI;
					default: m = MK_RST0 + 8'($urandom_range(0, 7));
				endcase
				file_buf.push_back(MK_FILL);
				file_buf.push_back(m);
			end
		end
		r = $urandom_range(0, 9);
		if (r < 4) begin
			add_segment(MK_SOS, $urandom_range(0, 3), 1'b0);
			repeat ($urandom_range(0, 8))
				file_buf.push_back(($urandom_range(0, 3) == 0) ? MK_FILL : 8'($urandom));
		end else if (r < 7) begin
			file_buf.push_back(MK_FILL);
			file_buf.push_back(MK_EOI);
		end
		if (broken && $urandom_range(0, 1) == 1)
			file_buf[$urandom_range(2, file_buf.size() - 1)] = 8'($urandom);
	endtask

	task automatic build_noise();
		file_buf.delete();
		if ($urandom_range(0, 1) == 1) begin
			file_buf.push_back(MK_FILL);
			file_buf.push_back(MK_SOI);
		end
		repeat ($urandom_range(1, 12))
			file_buf.push_back(($urandom_range(0, 1) == 1) ? MK_FILL : 8'($urandom));
	endtask

	initial begin
		int random_bytes;
		int fsize;
		int r;
		logic [LEN_W-1:0] len;
		jpeg_ch.valid   = 1'b0;
		jpeg_ch.in_byte = '0;
		jpeg_ch.in_last = 1'b0;
		filt_ch.ready   = 1'b0;
		file_len_cfg    = '0;
		reset_walk();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// total_length still at reset: no walk
		file_buf = '{8'h00, MK_FILL};
		queue_file(-1);

		// marker inside the last three bytes, then a lone byte ending while held
		set_file_length(LEN_W'(4));
		file_buf = '{MK_FILL, MK_SOI, MK_FILL, MK_EOI};
		queue_file(-1);
		file_buf = '{MK_FILL};
		queue_file(-1);

		// dropped segment up to the last byte: empty end result
		set_file_length(LEN_W'(7));
		file_buf = '{MK_FILL, MK_SOI, MK_FILL, MK_COM, 8'h00, 8'h03, 8'hAA};
		queue_file(-1);

		// saturated length; fill bytes, bare markers, short segment length
		set_file_length('1);
		file_buf = '{MK_FILL, MK_SOI, MK_FILL, MK_FILL, MK_RST0, MK_FILL, MK_TEM,
			MK_FILL, MK_DHT, 8'h00, 8'h01, 8'h00};
		queue_file(6);

		random_bytes = 0;
		while (random_bytes < RANDOM_BYTES) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				build_wellformed(1'b0);
			else if (r < 85)
				build_wellformed(1'b1);
			else
				build_noise();
			fsize = file_buf.size();
			r = $urandom_range(0, 99);
			if (r < 4)
				len = '0;
			else if (r < 8)
				len = LEN_W'(MAX_FILE_BYTES);
			else if (r < 16)
				len = LEN_W'((fsize > 3) ? fsize - $urandom_range(1, 3) : fsize);
			else if (r < 24)
				len = LEN_W'(fsize + $urandom_range(1, 5));
			else
				len = LEN_W'(fsize);
			set_file_length(len);
			calm_phase = ($urandom_range(0, 3) == 0);
			random_bytes += fsize;
			queue_file(($urandom_range(0, 9) == 0) ? $urandom_range(0, fsize - 1) : -1);
			if ($urandom_range(0, 4) == 0) begin
				if ($urandom_range(0, 1) == 1)
					build_noise();
				else
					build_wellformed(1'b0);
				random_bytes += file_buf.size();
				queue_file(-1);
			end
		end

		wait_idle(20);
		if (mismatches == 0 && filtered_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/jmsf_pkg.sv
src/jmsf_in_if.sv
src/jmsf_out_if.sv
src/jmsf_front.sv
src/jmsf_queue.sv
src/jmsf_back.sv
src/jpeg_marker_segment_filter.sv
tb/sv/jpeg_marker_segment_filter_tb.sv
